@@ design/dawt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-array trie walker package
// Shared field widths, the walker state type and table word layouts.
// ----------------------------------------------------------------------------
package dawt_pkg;

  localparam int NODE_W = 19;
  localparam int CHAR_W = 21;
  localparam int BASE_W = 22;
  localparam int LEN_W  = 8;
  // Signed base plus unsigned code point needs one bit more than the base.
  localparam int SUM_W  = BASE_W + 1;

  // Table words carry the used mark in the top bit.
  localparam int BASE_WORD_W   = BASE_W + 1;
  localparam int PARENT_WORD_W = NODE_W + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_PARENT,
    ST_EMIT
  } walk_state_t;

endpackage

@@ design/dawt_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Walker input channel
// Valid/ready channel carrying one load or character beat.
// ----------------------------------------------------------------------------
interface dawt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [dawt_pkg::NODE_W-1:0]       entry_index;
  logic signed [dawt_pkg::BASE_W-1:0] entry_base;
  logic                              entry_base_used;
  logic [dawt_pkg::NODE_W-1:0]       entry_parent;
  logic                              entry_parent_used;
  logic [dawt_pkg::CHAR_W-1:0]       char_code;
  logic                              word_first;

  modport source (
    output valid, func, entry_index, entry_base, entry_base_used,
           entry_parent, entry_parent_used, char_code, word_first,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_base, entry_base_used,
           entry_parent, entry_parent_used, char_code, word_first,
    output ready
  );
endinterface

@@ design/dawt_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Walker result channel
// Valid/ready channel carrying one walk result beat.
// ----------------------------------------------------------------------------
interface dawt_out_if;
  logic                        valid;
  logic                        ready;
  logic [dawt_pkg::NODE_W-1:0] node;
  logic [dawt_pkg::LEN_W-1:0]  matched_length;
  logic                        stopped;

  modport source (
    output valid, node, matched_length, stopped,
    input  ready
  );

  modport sink (
    input  valid, node, matched_length, stopped,
    output ready
  );
endinterface

@@ design/dawt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dawt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/double_array_trie_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-array trie walker
// Loads a double-array trie into two tables and walks it per character.
// ----------------------------------------------------------------------------
// Usage: the req channel takes two kinds of beats. A load beat (func = 0)
// writes one entry of the base and parent tables in the cycle it is taken;
// an index at or beyond TABLE_DEPTH is dropped. The whole table must be
// loaded before words are walked. A character beat (func = 1) produces
// exactly one beat on the rsp channel with the node reached, the matched
// length (saturating at 255) and a stopped flag. word_first restarts the
// walk at the root node. The user writes max_match through cfg_we/cfg_wdata
// only while the block is idle (not enforced); zero means no length limit.
//
// Operation: a character needs a base read and then a dependent parent read
// from the synchronous tables, so its result is registered from the parent
// state; it is registered from the base state when the base check already
// fails, and straight from idle when the walk is already stopped or the
// length limit is hit. The next beat is taken in the cycle in which the
// result first shows. A result waits in the output register while the
// receiver stalls; loads and a new character are still taken, and a
// following result waits in its final state until the output register
// frees. Reset clears the walk to node 0, length 0, not stopped, and
// max_match to zero; table contents are kept.
// ----------------------------------------------------------------------------
module double_array_trie_walker #(
  parameter int TABLE_DEPTH = 524288
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dawt_pkg::LEN_W-1:0] cfg_wdata,
  dawt_in_if.sink                    req,
  dawt_out_if.source                 rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  // The node register must hold any in-range table index and the node field.
  localparam int CW = (AW > dawt_pkg::NODE_W) ? AW : dawt_pkg::NODE_W;

  // Walk state registers.
  dawt_pkg::walk_state_t state, state_next;
  logic [CW-1:0]                 cur, cur_next;
  logic [dawt_pkg::LEN_W-1:0]    len, len_next;
  logic                          halted, halted_next;
  logic [dawt_pkg::CHAR_W-1:0]   ch, ch_next;
  logic [AW-1:0]                 tgt, tgt_next;
  logic [dawt_pkg::LEN_W-1:0]    max_match;

  // Output register.
  logic                          out_valid;
  logic [dawt_pkg::NODE_W-1:0]   out_node;
  logic [dawt_pkg::LEN_W-1:0]    out_len;
  logic                          out_stop;

  // Table ports.
  logic                                  tbl_we;
  logic [AW-1:0]                         tbl_waddr;
  logic                                  base_re, parent_re;
  logic [AW-1:0]                         base_raddr;
  logic [dawt_pkg::BASE_WORD_W-1:0]      base_wdata, base_rdata;
  logic [dawt_pkg::PARENT_WORD_W-1:0]    parent_wdata, parent_rdata;

  // Decoded conditions.
  logic                          in_fire, char_fire, load_fire;
  logic                          out_free, emit;
  logic [CW-1:0]                 eff_cur;
  logic [dawt_pkg::LEN_W-1:0]    eff_len;
  logic                          eff_halt, limit_hit, early_stop;
  logic signed [dawt_pkg::SUM_W-1:0] sum;
  logic                          base_fail, parent_ok;

  assign in_fire   = req.valid && req.ready;
  assign char_fire = in_fire && (req.func == dawt_pkg::FUNC_CHAR);
  assign load_fire = in_fire && (req.func == dawt_pkg::FUNC_LOAD);
  assign out_free  = !out_valid || rsp.ready;

  // A new word starts from the root with a clean length and no stop.
  assign eff_cur    = req.word_first ? '0 : cur;
  assign eff_len    = req.word_first ? '0 : len;
  assign eff_halt   = req.word_first ? 1'b0 : halted;
  assign limit_hit  = (max_match != '0) && (eff_len >= max_match);
  assign early_stop = eff_halt || limit_hit;

  // Target slot: signed base plus code point, checked against the table.
  assign sum = {base_rdata[dawt_pkg::BASE_W-1], base_rdata[dawt_pkg::BASE_W-1:0]}
             + $signed({2'b00, ch});
  assign base_fail = !base_rdata[dawt_pkg::BASE_W]
                  || sum[dawt_pkg::SUM_W-1]
                  || (32'(sum[dawt_pkg::SUM_W-2:0]) >= 32'(TABLE_DEPTH));

  // The step succeeds when the target is occupied and names the current node.
  assign parent_ok = parent_rdata[dawt_pkg::NODE_W]
                  && (CW'(parent_rdata[dawt_pkg::NODE_W-1:0]) == cur);

  // Load beats write both tables at the same index.
  assign tbl_we       = load_fire && (32'(req.entry_index) < 32'(TABLE_DEPTH));
  assign tbl_waddr    = AW'(req.entry_index);
  assign base_wdata   = {req.entry_base_used, req.entry_base};
  assign parent_wdata = {req.entry_parent_used, req.entry_parent};
  assign base_raddr   = eff_cur[AW-1:0];

  dawt_ram #(
    .WIDTH(dawt_pkg::BASE_WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_base_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(base_wdata),
    .re   (base_re),
    .raddr(base_raddr),
    .rdata(base_rdata)
  );

  dawt_ram #(
    .WIDTH(dawt_pkg::PARENT_WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_parent_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(parent_wdata),
    .re   (parent_re),
    .raddr(AW'(sum[dawt_pkg::SUM_W-2:0])),
    .rdata(parent_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      dawt_pkg::ST_IDLE: begin
        if (char_fire) begin
          if (!early_stop) begin
            state_next = dawt_pkg::ST_BASE;
          end else if (!out_free) begin
            state_next = dawt_pkg::ST_EMIT;
          end
        end
      end
      dawt_pkg::ST_BASE: begin
        if (!base_fail) begin
          state_next = dawt_pkg::ST_PARENT;
        end else begin
          state_next = out_free ? dawt_pkg::ST_IDLE : dawt_pkg::ST_EMIT;
        end
      end
      dawt_pkg::ST_PARENT: begin
        state_next = out_free ? dawt_pkg::ST_IDLE : dawt_pkg::ST_EMIT;
      end
      dawt_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = dawt_pkg::ST_IDLE;
        end
      end
      default: state_next = dawt_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    req.ready   = 1'b0;
    base_re     = 1'b0;
    parent_re   = 1'b0;
    emit        = 1'b0;
    cur_next    = cur;
    len_next    = len;
    halted_next = halted;
    ch_next     = ch;
    tgt_next    = tgt;
    unique case (state)
      dawt_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (char_fire) begin
          ch_next     = req.char_code;
          cur_next    = eff_cur;
          len_next    = eff_len;
          halted_next = early_stop;
          base_re     = !early_stop;
          emit        = early_stop;
        end
      end
      dawt_pkg::ST_BASE: begin
        if (base_fail) begin
          halted_next = 1'b1;
          emit        = 1'b1;
        end else begin
          parent_re = 1'b1;
          tgt_next  = AW'(sum[dawt_pkg::SUM_W-2:0]);
        end
      end
      dawt_pkg::ST_PARENT: begin
        emit = 1'b1;
        if (parent_ok) begin
          cur_next = CW'(tgt);
          if (len != dawt_pkg::LEN_MAX) begin
            len_next = len + 1'b1;
          end
        end else begin
          halted_next = 1'b1;
        end
      end
      dawt_pkg::ST_EMIT: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dawt_pkg::ST_IDLE;
      cur       <= '0;
      len       <= '0;
      halted    <= 1'b0;
      max_match <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      len    <= len_next;
      halted <= halted_next;
      if (cfg_we) begin
        max_match <= cfg_wdata;
      end
      if (emit && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch  <= ch_next;
    tgt <= tgt_next;
    if (emit && out_free) begin
      out_node <= cur_next[dawt_pkg::NODE_W-1:0];
      out_len  <= len_next;
      out_stop <= halted_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.node           = out_node;
  assign rsp.matched_length = out_len;
  assign rsp.stopped        = out_stop;

endmodule

@@ design/dawt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-array trie walker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dawt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_we,
  input logic [dawt_pkg::LEN_W-1:0] cfg_wdata,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dawt_pkg::NODE_W-1:0] out_node,
  input logic [dawt_pkg::LEN_W-1:0] out_len,
  input logic                       out_stop
);

  // Shadow of the length limit as seen on the configuration port.
  logic [dawt_pkg::LEN_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_node)
      && $stable(out_len) && $stable(out_stop))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat presented after reset");

  // A walk that has not stopped has matched at least one character.
  a_live_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stop |-> out_len != '0)
    else $error("running walk reports zero length");

  // A running walk never goes past the configured limit.
  a_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stop && limit != '0 |-> out_len <= limit)
    else $error("matched length beyond limit");

endmodule

bind double_array_trie_walker dawt_checker u_dawt_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .cfg_wdata(cfg_wdata),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .out_node (rsp.node),
  .out_len  (rsp.matched_length),
  .out_stop (rsp.stopped)
);
